// File: src/jsu_pkg.sv
package jsu_pkg;

    // Input request: one source byte or the end-of-source mark
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    // Result request: one decoded byte, a close mark or an error
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last;
    } out_item_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CONTROL  = 3'd1;
    localparam logic [2:0] ERR_END_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd3;
    localparam logic [2:0] ERR_SHORT    = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd5;
    localparam logic [2:0] ERR_BAD_PAIR = 3'd6;
    localparam logic [2:0] ERR_UNTERM   = 3'd7;

    // Decoder phases
    typedef enum logic [2:0] {
        PH_BODY,
        PH_ESC,
        PH_QUAD1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_QUAD2,
        PH_WAIT
    } phase_t;

    // Work entry kinds passed from front to back
    typedef enum logic [1:0] {
        ENT_RAW,
        ENT_CP,
        ENT_CLOSE,
        ENT_ERROR
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t   kind;
        logic [20:0] cp;
        logic [2:0]  err;
    } entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Number of UTF-8 bytes for a code point, minus one
    function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7F) begin
            n = 2'd0;
        end else if (cp <= 21'h7FF) begin
            n = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Byte number idx of the UTF-8 form of cp
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (len_m1)
            2'd0: b = cp[7:0];
            2'd1:
            begin
                if (idx == 2'd0) b = 8'hC0 | {3'b000, cp[10:6]};
                else             b = 8'h80 | {2'b00, cp[5:0]};
            end
            2'd2:
            begin
                case (idx)
                    2'd0:    b = 8'hE0 | {4'b0000, cp[15:12]};
                    2'd1:    b = 8'h80 | {2'b00, cp[11:6]};
                    default: b = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = 8'hF0 | {5'b00000, cp[20:18]};
                    2'd1:    b = 8'h80 | {2'b00, cp[17:12]};
                    2'd2:    b = 8'h80 | {2'b00, cp[11:6]};
                    default: b = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// File: src/jsu_front.sv
module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  jsu_pkg::in_item_t  item,
    output logic               ent_valid,
    output jsu_pkg::entry_t    ent
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  hex_count_reg, hex_count_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic        hex_bad_reg, hex_bad_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic [7:0]  b;
    logic [3:0]  nib;
    logic        digit_ok;
    logic [15:0] quad_value;
    logic        quad_bad;
    logic        quad_done;

    // Hold decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsu_pkg::PH_BODY;
            hex_count_reg <= 3'd0;
            hex_value_reg <= 16'd0;
            hex_bad_reg   <= 1'b0;
            high_half_reg <= 10'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hex_count_reg <= hex_count_next;
            hex_value_reg <= hex_value_next;
            hex_bad_reg   <= hex_bad_next;
            high_half_reg <= high_half_next;
        end
    end

    // Judge the incoming byte as a quad digit
    always_comb
    begin
        b        = item.in_byte;
        nib      = 4'd0;
        digit_ok = 1'b1;
        if (b >= 8'h30 && b <= 8'h39) begin
            nib = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            nib = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            nib = 4'(b - 8'h37);
        end else begin
            digit_ok = 1'b0;
        end
        quad_value = {hex_value_reg[11:0], nib};
        quad_bad   = hex_bad_reg | ~digit_ok;
        quad_done  = (hex_count_reg == 3'd3);
    end

    // Advance the phase and classify the request
    always_comb
    begin
        phase_next     = phase_reg;
        hex_count_next = hex_count_reg;
        hex_value_next = hex_value_reg;
        hex_bad_next   = hex_bad_reg;
        high_half_next = high_half_reg;
        ent_valid      = 1'b0;
        ent.kind       = jsu_pkg::ENT_RAW;
        ent.cp         = {13'd0, b};
        ent.err        = jsu_pkg::ERR_NONE;

        if (take)
        begin
            if (item.end_of_input)
            begin
                // Source ended: rearm for a new string, flag what was open
                phase_next     = jsu_pkg::PH_BODY;
                hex_count_next = 3'd0;
                hex_value_next = 16'd0;
                hex_bad_next   = 1'b0;
                high_half_next = 10'd0;
                ent.kind       = jsu_pkg::ENT_ERROR;
                ent.cp         = 21'd0;
                ent_valid      = 1'b1;
                case (phase_reg)
                    jsu_pkg::PH_BODY:    ent.err = jsu_pkg::ERR_UNTERM;
                    jsu_pkg::PH_ESC:     ent.err = jsu_pkg::ERR_END_ESC;
                    jsu_pkg::PH_QUAD1,
                    jsu_pkg::PH_QUAD2:   ent.err = jsu_pkg::ERR_SHORT;
                    jsu_pkg::PH_WANT_BS,
                    jsu_pkg::PH_WANT_U:  ent.err = jsu_pkg::ERR_BAD_PAIR;
                    default:             ent_valid = 1'b0;
                endcase
            end
            else
            begin
                case (phase_reg)
                    jsu_pkg::PH_BODY:
                    begin
                        if (b == 8'h22)
                        begin
                            phase_next = jsu_pkg::PH_WAIT;
                            ent.kind   = jsu_pkg::ENT_CLOSE;
                            ent.cp     = 21'd0;
                            ent_valid  = 1'b1;
                        end
                        else if (b < 8'h20)
                        begin
                            phase_next = jsu_pkg::PH_WAIT;
                            ent.kind   = jsu_pkg::ENT_ERROR;
                            ent.cp     = 21'd0;
                            ent.err    = jsu_pkg::ERR_CONTROL;
                            ent_valid  = 1'b1;
                        end
                        else if (b == 8'h5C)
                        begin
                            phase_next = jsu_pkg::PH_ESC;
                        end
                        else
                        begin
                            ent_valid = 1'b1;
                        end
                    end
                    jsu_pkg::PH_ESC:
                    begin
                        phase_next = jsu_pkg::PH_BODY;
                        ent_valid  = 1'b1;
                        case (b)
                            8'h22, 8'h5C, 8'h2F: ent.cp = {13'd0, b};
                            8'h62:               ent.cp = 21'h08;
                            8'h66:               ent.cp = 21'h0C;
                            8'h6E:               ent.cp = 21'h0A;
                            8'h72:               ent.cp = 21'h0D;
                            8'h74:               ent.cp = 21'h09;
                            8'h75:
                            begin
                                phase_next     = jsu_pkg::PH_QUAD1;
                                hex_count_next = 3'd0;
                                hex_value_next = 16'd0;
                                hex_bad_next   = 1'b0;
                                ent_valid      = 1'b0;
                            end
                            default:
                            begin
                                phase_next     = jsu_pkg::PH_WAIT;
                                high_half_next = 10'd0;
                                ent.kind       = jsu_pkg::ENT_ERROR;
                                ent.cp         = 21'd0;
                                ent.err        = jsu_pkg::ERR_BAD_ESC;
                            end
                        endcase
                    end
                    jsu_pkg::PH_QUAD1, jsu_pkg::PH_QUAD2:
                    begin
                        hex_count_next = hex_count_reg + 3'd1;
                        hex_value_next = quad_value;
                        hex_bad_next   = quad_bad;
                        if (quad_done)
                        begin
                            // Fourth digit: judge the quad
                            hex_count_next = 3'd0;
                            hex_value_next = 16'd0;
                            hex_bad_next   = 1'b0;
                            ent_valid      = 1'b1;
                            ent.kind       = jsu_pkg::ENT_ERROR;
                            ent.cp         = 21'd0;
                            if (quad_bad)
                            begin
                                phase_next     = jsu_pkg::PH_WAIT;
                                high_half_next = 10'd0;
                                ent.err        = jsu_pkg::ERR_BAD_HEX;
                            end
                            else if (phase_reg == jsu_pkg::PH_QUAD1)
                            begin
                                if (quad_value < 16'hD800 || quad_value > 16'hDFFF)
                                begin
                                    phase_next = jsu_pkg::PH_BODY;
                                    ent.kind   = jsu_pkg::ENT_CP;
                                    ent.cp     = {5'd0, quad_value};
                                end
                                else if (quad_value > 16'hDBFF)
                                begin
                                    phase_next     = jsu_pkg::PH_WAIT;
                                    high_half_next = 10'd0;
                                    ent.err        = jsu_pkg::ERR_BAD_PAIR;
                                end
                                else
                                begin
                                    phase_next     = jsu_pkg::PH_WANT_BS;
                                    high_half_next = quad_value[9:0];
                                    ent_valid      = 1'b0;
                                end
                            end
                            else
                            begin
                                high_half_next = 10'd0;
                                if (quad_value < 16'hDC00 || quad_value > 16'hDFFF)
                                begin
                                    phase_next = jsu_pkg::PH_WAIT;
                                    ent.err    = jsu_pkg::ERR_BAD_PAIR;
                                end
                                else
                                begin
                                    // Join the surrogate halves
                                    phase_next = jsu_pkg::PH_BODY;
                                    ent.kind   = jsu_pkg::ENT_CP;
                                    ent.cp     = {1'b0, high_half_reg, quad_value[9:0]}
                                                 + 21'h10000;
                                end
                            end
                        end
                    end
                    jsu_pkg::PH_WANT_BS, jsu_pkg::PH_WANT_U:
                    begin
                        if ((phase_reg == jsu_pkg::PH_WANT_BS && b == 8'h5C) ||
                            (phase_reg == jsu_pkg::PH_WANT_U && b == 8'h75))
                        begin
                            phase_next     = (phase_reg == jsu_pkg::PH_WANT_BS) ?
                                             jsu_pkg::PH_WANT_U : jsu_pkg::PH_QUAD2;
                            hex_count_next = 3'd0;
                            hex_value_next = 16'd0;
                            hex_bad_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next     = jsu_pkg::PH_WAIT;
                            hex_count_next = 3'd0;
                            hex_value_next = 16'd0;
                            hex_bad_next   = 1'b0;
                            high_half_next = 10'd0;
                            ent.kind       = jsu_pkg::ENT_ERROR;
                            ent.cp         = 21'd0;
                            ent.err        = jsu_pkg::ERR_BAD_PAIR;
                            ent_valid      = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = jsu_pkg::PH_WAIT;
                    end
                endcase
            end
        end
    end

endmodule

// File: src/jsu_queue.sv
module jsu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  jsu_pkg::entry_t  wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output jsu_pkg::entry_t  rd_data,
    output logic             q_empty
);

    jsu_pkg::entry_t slot_reg [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [jsu_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [jsu_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic do_wr, do_rd;

    // Qualify requests against fill level
    always_comb
    begin
        q_full      = (count_reg == (jsu_pkg::QUEUE_AW+1)'(jsu_pkg::QUEUE_DEPTH));
        q_empty     = (count_reg == '0);
        do_wr       = wr_en & ~q_full;
        do_rd       = rd_en & ~q_empty;
        wr_ptr_next = wr_ptr_reg + (jsu_pkg::QUEUE_AW)'(do_wr);
        rd_ptr_next = rd_ptr_reg + (jsu_pkg::QUEUE_AW)'(do_rd);
        count_next  = count_reg + (jsu_pkg::QUEUE_AW+1)'(do_wr)
                                - (jsu_pkg::QUEUE_AW+1)'(do_rd);
        rd_data     = slot_reg[rd_ptr_reg];
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/jsu_back.sv
module jsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::entry_t     head,
    input  logic                head_empty,
    output logic                head_pop,
    output jsu_pkg::out_item_t  result,
    output logic                empty,
    input  logic                pop
);

    jsu_pkg::out_item_t out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] len_m1;
    logic       advance;
    logic       is_last;

    // Expand the head entry into one result byte per cycle while the output register is free or popped
    always_comb
    begin
        advance        = ~out_valid_reg | pop;
        out_valid_next = out_valid_reg & ~pop;
        out_next       = out_reg;
        idx_next       = idx_reg;
        head_pop       = 1'b0;
        len_m1         = (head.kind == jsu_pkg::ENT_CP) ? jsu_pkg::utf8_len_m1(head.cp) : 2'd0;
        is_last        = (idx_reg == len_m1);

        if (advance && !head_empty)
        begin
            out_valid_next      = 1'b1;
            out_next.last       = is_last;
            out_next.error_code = jsu_pkg::ERR_NONE;
            out_next.kind       = jsu_pkg::KIND_DATA;
            out_next.out_byte   = 8'h00;
            case (head.kind)
                jsu_pkg::ENT_RAW:   out_next.out_byte = head.cp[7:0];
                jsu_pkg::ENT_CP:    out_next.out_byte = jsu_pkg::utf8_byte(head.cp, len_m1,
                                                                           idx_reg);
                jsu_pkg::ENT_CLOSE: out_next.kind = jsu_pkg::KIND_CLOSE;
                default:
                begin
                    out_next.kind       = jsu_pkg::KIND_ERROR;
                    out_next.error_code = head.err;
                end
            endcase
            if (is_last)
            begin
                head_pop = 1'b1;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        empty = ~out_valid_reg;
        result = out_reg;
    end

    // Hold the output register and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: src/json_string_unescape_utf8.sv
// JSON string body unescaper with UTF-8 output.
// Input channel: drive item (in_byte, end_of_input) with push; a request is
// taken at a rising edge with push high and full low. Feed the bytes after
// the opening quote; end_of_input marks the end of the source.
// Result channel: while empty is low, result holds the oldest waiting byte,
// close mark or error; it is taken at an edge with pop high.
// With nothing older waiting, the decoder writes an item's first entry into the
// work queue at the edge that takes the item, and the output register loads the
// first result at the next one.
// Throughput: one item per cycle while full is low, as long as each item yields
// at most one result; a \uXXXX escape that becomes 2 or 3 UTF-8 bytes, or a
// surrogate pair that becomes 4, occupies the output side longer, held by the
// byte expander's single output register. The four-entry work queue between
// decoder and expander absorbs this, and full rises only once it fills.
// Reset clears decoder state, the queue and the output valid flag; the block
// then waits for a fresh string body. If the receiver stalls, the output
// register holds, the queue fills and full goes high until pop resumes.
module json_string_unescape_utf8 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  jsu_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output jsu_pkg::out_item_t  result
);

    logic            take;
    logic            ent_valid;
    jsu_pkg::entry_t ent;
    jsu_pkg::entry_t head;
    logic            head_empty;
    logic            head_pop;

    assign take = push & ~full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .ent_valid (ent_valid),
        .ent       (ent)
    );

    jsu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ent_valid),
        .wr_data (ent),
        .q_full  (full),
        .rd_en   (head_pop),
        .rd_data (head),
        .q_empty (head_empty)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// File: tb/sv/json_unescape_check_pkg.sv
`timescale 1ns / 1ps

package json_unescape_check_pkg;
    import jsu_pkg::*;

    // Source characters with a meaning to the decoder
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Decoder mirror plus the queue of decoded bytes still owed by the block
    class unescape_board;
        out_item_t   expected_q[$];
        int          fail_count;
        phase_t      phase;
        logic [2:0]  digit_count;
        logic [15:0] quad_value;
        logic        quad_bad;
        logic [9:0]  high_half;

        function new();
            fail_count = 0;
            phase = PH_BODY;
            clear_quad();
            high_half = 10'd0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void clear_quad();
            digit_count = 3'd0;
            quad_value = 16'd0;
            quad_bad = 1'b0;
        endfunction

        function void queue_result(logic [7:0] b, logic [1:0] k, logic [2:0] code);
            out_item_t r;
            r.out_byte = b;
            r.kind = k;
            r.error_code = code;
            r.last = 1'b0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Drop the string; an error from end of source arms a new body at once
        function void raise_error(logic [2:0] code, bit source_ended);
            phase = source_ended ? PH_BODY : PH_WAIT;
            clear_quad();
            high_half = 10'd0;
            queue_result(8'h00, KIND_ERROR, code);
        endfunction

        // Split a code point into its UTF-8 bytes
        function void queue_utf8(logic [20:0] cp);
            if (cp <= 21'h7F)
            begin
                queue_result(cp[7:0], KIND_DATA, ERR_NONE);
            end
            else if (cp <= 21'h7FF)
            begin
                queue_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
                queue_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end
            else if (cp <= 21'hFFFF)
            begin
                queue_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
                queue_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                queue_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end
            else
            begin
                queue_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
                queue_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
                queue_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                queue_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end
        endfunction

        // Shift in one quad digit; a non-hex byte counts as zero and marks the quad
        function bit shift_digit(logic [7:0] b);
            logic [3:0] nib;
            nib = 4'd0;
            if (b >= CH_ZERO && b <= CH_ZERO + 8'd9)
            begin
                nib = 4'(b - CH_ZERO);
            end
            else if (b >= CH_LOWER_A && b <= CH_LOWER_A + 8'd5)
            begin
                nib = 4'(b - CH_LOWER_A + 8'd10);
            end
            else if (b >= CH_UPPER_A && b <= CH_UPPER_A + 8'd5)
            begin
                nib = 4'(b - CH_UPPER_A + 8'd10);
            end
            else
            begin
                quad_bad = 1'b1;
            end
            quad_value = {quad_value[11:0], nib};
            digit_count = digit_count + 3'd1;
            return digit_count >= 3'd4;
        endfunction

        function void take_byte(logic [7:0] b);
            logic [15:0] v;
            logic [20:0] cp;
            case (phase)
                PH_BODY:
                begin
                    if (b == CH_QUOTE)
                    begin
                        phase = PH_WAIT;
                        queue_result(8'h00, KIND_CLOSE, ERR_NONE);
                    end
                    else if (b < CTRL_LIMIT)
                    begin
                        raise_error(ERR_CONTROL, 1'b0);
                    end
                    else if (b == CH_BSLASH)
                    begin
                        phase = PH_ESC;
                    end
                    else
                    begin
                        queue_result(b, KIND_DATA, ERR_NONE);
                    end
                end
                PH_ESC:
                begin
                    phase = PH_BODY;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: queue_result(b, KIND_DATA, ERR_NONE);
                        CH_B: queue_result(8'h08, KIND_DATA, ERR_NONE);
                        CH_F: queue_result(8'h0C, KIND_DATA, ERR_NONE);
                        CH_N: queue_result(8'h0A, KIND_DATA, ERR_NONE);
                        CH_R: queue_result(8'h0D, KIND_DATA, ERR_NONE);
                        CH_T: queue_result(8'h09, KIND_DATA, ERR_NONE);
                        CH_U:
                        begin
                            clear_quad();
                            phase = PH_QUAD1;
                        end
                        default: raise_error(ERR_BAD_ESC, 1'b0);
                    endcase
                end
                PH_QUAD1:
                begin
                    if (shift_digit(b))
                    begin
                        if (quad_bad)
                        begin
                            raise_error(ERR_BAD_HEX, 1'b0);
                        end
                        else
                        begin
                            v = quad_value;
                            clear_quad();
                            if (v < 16'hD800 || v > 16'hDFFF)
                            begin
                                phase = PH_BODY;
                                queue_utf8({5'd0, v});
                            end
                            else if (v > 16'hDBFF)
                            begin
                                raise_error(ERR_BAD_PAIR, 1'b0);
                            end
                            else
                            begin
                                // keep the high half's offset from the surrogate base
                                high_half = v[9:0];
                                phase = PH_WANT_BS;
                            end
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (b != CH_BSLASH)
                        raise_error(ERR_BAD_PAIR, 1'b0);
                    else
                        phase = PH_WANT_U;
                end
                PH_WANT_U:
                begin
                    if (b != CH_U)
                    begin
                        raise_error(ERR_BAD_PAIR, 1'b0);
                    end
                    else
                    begin
                        clear_quad();
                        phase = PH_QUAD2;
                    end
                end
                PH_QUAD2:
                begin
                    if (shift_digit(b))
                    begin
                        v = quad_value;
                        if (quad_bad)
                        begin
                            raise_error(ERR_BAD_HEX, 1'b0);
                        end
                        else if (v < 16'hDC00 || v > 16'hDFFF)
                        begin
                            raise_error(ERR_BAD_PAIR, 1'b0);
                        end
                        else
                        begin
                            clear_quad();
                            phase = PH_BODY;
                            cp = 21'h10000 + {1'b0, high_half, 10'd0} + {11'd0, v[9:0]};
                            high_half = 10'd0;
                            queue_utf8(cp);
                        end
                    end
                end
                default: phase = PH_WAIT;
            endcase
        endfunction

        // End of source: error unless the string was already closed or dropped
        function void close_source();
            case (phase)
                PH_BODY: raise_error(ERR_UNTERM, 1'b1);
                PH_ESC: raise_error(ERR_END_ESC, 1'b1);
                PH_QUAD1, PH_QUAD2: raise_error(ERR_SHORT, 1'b1);
                PH_WANT_BS, PH_WANT_U: raise_error(ERR_BAD_PAIR, 1'b1);
                default:
                begin
                    phase = PH_BODY;
                    clear_quad();
                    high_half = 10'd0;
                end
            endcase
        endfunction

        // Advance the mirror by one accepted request and flag its final result
        function void note_request(in_item_t req);
            int prior_size;
            prior_size = expected_q.size();
            if (req.end_of_input)
                close_source();
            else
                take_byte(req.in_byte);
            if (expected_q.size() > prior_size)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function bit field_mismatch(string label, logic [7:0] want, logic [7:0] seen);
            if (seen !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, seen);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Compare one popped result against the oldest owed result
        function void check_result(out_item_t got);
            out_item_t want;
            bit        bad;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            bad = field_mismatch("out_byte", want.out_byte, got.out_byte);
            bad |= field_mismatch("kind", {6'd0, want.kind}, {6'd0, got.kind});
            bad |= field_mismatch("error_code", {5'd0, want.error_code}, {5'd0, got.error_code});
            bad |= field_mismatch("last", {7'd0, want.last}, {7'd0, got.last});
            if (bad)
                fail_count++;
        endfunction
    endclass

endpackage

// File: tb/sv/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;
    import jsu_pkg::*;
    import json_unescape_check_pkg::*;

    localparam int SOURCE_ITEMS    = 205;
    localparam int QUIET_TAIL      = 40;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    in_item_t  item = '0;
    out_item_t result;

    in_item_t      source_q[$];
    int            sent_count = 0;
    bit            quiet = 1'b0;
    bit            holding = 1'b0;
    unescape_board board;

    json_string_unescape_utf8 i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Track every accepted request and popped result at the edge
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_request(item);
        if (rst_n && pop && !empty)
            board.check_result(result);
    end

    function automatic void add_byte(logic [7:0] b);
        in_item_t r;
        r.in_byte = b;
        r.end_of_input = 1'b0;
        source_q.insert(source_q.size(), r);
    endfunction

    function automatic void add_end();
        in_item_t r;
        r.in_byte = 8'($urandom_range(0, 255));
        r.end_of_input = 1'b1;
        source_q.insert(source_q.size(), r);
    endfunction

    function automatic void add_escape(logic [7:0] letter);
        add_byte(CH_BSLASH);
        add_byte(letter);
    endfunction

    function automatic void add_hex_digit(logic [3:0] n);
        if (n < 4'd10)
            add_byte(CH_ZERO + 8'(n));
        else if ($urandom_range(0, 1) == 0)
            add_byte(CH_LOWER_A + 8'(n) - 8'd10);
        else
            add_byte(CH_UPPER_A + 8'(n) - 8'd10);
    endfunction

    function automatic void add_quad(logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            add_hex_digit(v[i * 4 +: 4]);
    endfunction

    // Four digits with one non-hex byte at a random place
    function automatic void add_bad_quad();
        int         pos;
        logic [7:0] nb;
        pos = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
        begin
            if (i == pos)
            begin
                do
                    nb = 8'($urandom_range(0, 255));
                while ((nb >= CH_ZERO && nb <= CH_ZERO + 8'd9)
                       || (nb >= CH_LOWER_A && nb <= CH_LOWER_A + 8'd5)
                       || (nb >= CH_UPPER_A && nb <= CH_UPPER_A + 8'd5));
                add_byte(nb);
            end
            else
            begin
                add_hex_digit(4'($urandom_range(0, 15)));
            end
        end
    endfunction

    function automatic void add_high();
        add_escape(CH_U);
        case ($urandom_range(0, 3))
            0: add_quad(16'hD800);
            1: add_quad(16'hDBFF);
            default: add_quad(16'($urandom_range(16'hD800, 16'hDBFF)));
        endcase
    endfunction

    function automatic void add_partial_quad();
        int k;
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++)
            add_hex_digit(4'($urandom_range(0, 15)));
    endfunction

    // Bytes after a close or error are skipped until end of source
    function automatic void add_ignored();
        int n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    // One well-formed piece of a string body
    function automatic void add_segment();
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            do
                b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                                : 8'($urandom_range(8'h20, 8'hFF));
            while (b == CH_QUOTE || b == CH_BSLASH);
            add_byte(b);
        end
        else if (pick < 55)
        begin
            case ($urandom_range(0, 7))
                0: add_escape(CH_QUOTE);
                1: add_escape(CH_BSLASH);
                2: add_escape(CH_SLASH);
                3: add_escape(CH_B);
                4: add_escape(CH_F);
                5: add_escape(CH_N);
                6: add_escape(CH_R);
                default: add_escape(CH_T);
            endcase
        end
        else if (pick < 80)
        begin
            add_escape(CH_U);
            case ($urandom_range(0, 11))
                0: add_quad(16'h0000);
                1: add_quad(16'h007F);
                2: add_quad(16'h0080);
                3: add_quad(16'h07FF);
                4: add_quad(16'h0800);
                5: add_quad(16'hD7FF);
                6: add_quad(16'hE000);
                7: add_quad(16'hFFFF);
                8: add_quad(16'($urandom_range(0, 16'h7F)));
                9: add_quad(16'($urandom_range(16'h80, 16'h7FF)));
                10: add_quad(16'($urandom_range(16'h800, 16'hD7FF)));
                default: add_quad(16'($urandom_range(16'hE000, 16'hFFFF)));
            endcase
        end
        else
        begin
            add_high();
            add_escape(CH_U);
            case ($urandom_range(0, 3))
                0: add_quad(16'hDC00);
                1: add_quad(16'hDFFF);
                default: add_quad(16'($urandom_range(16'hDC00, 16'hDFFF)));
            endcase
        end
    endfunction

    // A byte that breaks the string; the block then waits for end of source
    function automatic void add_byte_fault();
        logic [7:0]  b;
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: add_byte(8'($urandom_range(0, 8'h1F)));
            1:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B
                       || b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
                add_escape(b);
            end
            2:
            begin
                add_escape(CH_U);
                add_bad_quad();
            end
            3:
            begin
                add_escape(CH_U);
                add_quad(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            4:
            begin
                add_high();
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_BSLASH);
                add_byte(b);
            end
            5:
            begin
                add_high();
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_U);
                add_escape(b);
            end
            6:
            begin
                add_high();
                add_escape(CH_U);
                do
                    v = 16'($urandom_range(0, 16'hFFFF));
                while (v >= 16'hDC00 && v <= 16'hDFFF);
                add_quad(v);
            end
            default:
            begin
                add_high();
                add_escape(CH_U);
                add_bad_quad();
            end
        endcase
    endfunction

    // A source that ends inside the string; the block rearms at once
    function automatic void add_end_fault();
        case ($urandom_range(0, 5))
            0: ;
            1: add_byte(CH_BSLASH);
            2:
            begin
                add_escape(CH_U);
                add_partial_quad();
            end
            3: add_high();
            4:
            begin
                add_high();
                add_byte(CH_BSLASH);
            end
            default:
            begin
                add_high();
                add_escape(CH_U);
                add_partial_quad();
            end
        endcase
        add_end();
    endfunction

    function automatic void add_string();
        int segs;
        int ending;
        segs = $urandom_range(0, 8);
        for (int i = 0; i < segs; i++)
            add_segment();
        ending = $urandom_range(0, 99);
        if (ending < 60)
        begin
            add_byte(CH_QUOTE);
            add_ignored();
            add_end();
        end
        else if (ending < 78)
        begin
            add_byte_fault();
            add_ignored();
            add_end();
        end
        else
        begin
            add_end_fault();
        end
    endfunction

    // Build the byte stream: a short fixed opening, then random strings
    function automatic void build_source();
        add_byte(8'hFF);
        add_escape(CH_U);
        add_quad(16'h00E9);
        add_escape(CH_U);
        add_quad(16'hD83D);
        add_escape(CH_U);
        add_quad(16'hDE00);
        add_byte(CH_QUOTE);
        add_end();
        add_byte(8'h00);
        add_end();
        while (source_q.size() < SOURCE_ITEMS)
            add_string();
    endfunction

    // Offer source bytes, idling in bursts away from the tail and the hold-off
    task automatic drive_requests();
        int gap;
        int idle_rate;
        idle_rate = 0;
        while (sent_count < source_q.size())
        begin
            if (sent_count % 32 == 0)
                idle_rate = $urandom_range(0, 2);
            if (!quiet && !holding && idle_rate != 0
                && $urandom_range(0, 6 - 2 * idle_rate) == 0)
            begin
                gap = $urandom_range(1, 15);
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push <= 1'b1;
            item <= source_q[sent_count];
            @(posedge clk);
            while (full)
                @(posedge clk);
            sent_count++;
            quiet = (sent_count >= source_q.size() - QUIET_TAIL);
        end
        push <= 1'b0;
    endtask

    // Pop results with random stalls and one long hold-off to fill the block
    task automatic drain_results();
        int stall_left;
        int stall_rate;
        int pressure_left;
        int cycle_count;
        bit pressure_done;
        stall_left = 0;
        stall_rate = 0;
        pressure_left = 0;
        cycle_count = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count % 64 == 0)
                stall_rate = $urandom_range(0, 2);
            if (pressure_left > 0)
            begin
                pop <= 1'b0;
                pressure_left--;
                if (pressure_left == 0)
                    holding = 1'b0;
            end
            else if (!pressure_done && sent_count >= HOLD_OFF_AT)
            begin
                pressure_done = 1'b1;
                holding = 1'b1;
                pressure_left = HOLD_OFF_CYCLES;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!quiet && stall_rate != 0 && $urandom_range(0, 4 - stall_rate) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    endtask

    initial
    begin
        board = new();
        build_source();
        fork
            drain_results();
        join_none
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        drive_requests();
        // wait for every owed result, then watch for strays
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.fail_count == 0)
            $display("json_string_unescape_utf8 regression: pass");
        else
            $display("json_string_unescape_utf8 regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("json_string_unescape_utf8 regression: fail");
        $finish;
    end

endmodule
